/* rtl/bdq_pkg.sv */
// Shared types, constants and command codes for the bounded deque with drop.
package bdq_pkg;

  // Ring storage geometry.
  localparam int DEPTH       = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Fixed field widths of the ports.
  localparam int KIND_W = 3;
  localparam int CAP_W  = 7;
  localparam int OCC_W  = 7;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAKE_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TAKE_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SYNC_ACK   = 3'd4;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // Input item.
  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [ENTRY_WIDTH-1:0] entry_data;
  } cmd_t;

  // Result item.
  typedef struct packed {
    logic                   out_valid;
    logic [ENTRY_WIDTH-1:0] out_data;
    logic                   evicted;
    logic [OCC_W-1:0]       occupancy;
    logic                   dirty;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

/* rtl/bdq_ctrl.sv */
// Controller state machine: accepts an item, then runs its execute cycle.
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output bdq_pkg::ctl_t ctl
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and result strobe, which follows the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
    end
  end

  // Commands to the datapath.
  assign busy     = (state != ST_IDLE);
  assign ctl.load = start && (state == ST_IDLE);
  assign ctl.exec = (state == ST_EXEC);

endmodule

/* rtl/bdq_datapath.sv */
// Datapath: ring memory, end pointers, count, dirty flag and capacity register.
module bdq_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  bdq_pkg::ctl_t          ctl,
  input  bdq_pkg::cmd_t          cmd,
  input  logic                   cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_data,
  output bdq_pkg::result_t       result
);
  import bdq_pkg::*;

  // Ring storage; read data is only used while the deque is occupied.
  logic [ENTRY_WIDTH-1:0] mem [DEPTH];

  logic [IDX_W-1:0]       front;
  logic [CNT_W-1:0]       count;
  logic                   dirty;
  logic [CAP_W-1:0]       capacity;

  logic [KIND_W-1:0]      op_kind;
  logic [ENTRY_WIDTH-1:0] op_data;
  logic [ENTRY_WIDTH-1:0] rd_data;

  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       back_idx;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;
  logic                   is_push;
  logic                   is_take;
  logic                   rem;
  logic                   rem_front;
  logic [CNT_W-1:0]       count1;
  logic [IDX_W-1:0]       front1;
  logic [IDX_W-1:0]       front_next;
  logic [CNT_W-1:0]       count_next;
  logic                   dirty_next;
  logic [IDX_W-1:0]       wr_addr;

  // Slot of the back entry for the current pointers.
  assign back_idx = front + count[IDX_W-1:0] - IDX_W'(1);

  // Read address at acceptance: front slot or back slot by kind.
  always_comb begin
    case (cmd.kind)
      KIND_PUSH_FRONT, KIND_TAKE_BACK: rd_addr = back_idx;
      default:                          rd_addr = front;
    endcase
  end

  // Registered read and latch of the accepted item.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rd_data <= mem[rd_addr];
      op_kind <= cmd.kind;
      op_data <= cmd.entry_data;
    end
  end

  // Capacity of zero acts as one, and anything above the ring size saturates.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  assign full      = (CMP_W'(count) >= eff_cap);
  assign is_push   = (op_kind == KIND_PUSH_BACK) || (op_kind == KIND_PUSH_FRONT);
  assign is_take   = (op_kind == KIND_TAKE_FRONT) || (op_kind == KIND_TAKE_BACK);
  assign rem_front = (op_kind == KIND_PUSH_BACK) || (op_kind == KIND_TAKE_FRONT);
  assign rem       = (count != '0) && ((is_push && full) || is_take);

  // Removal step: an eviction or a take drops one entry from one end.
  always_comb begin
    count1 = rem ? (count - CNT_W'(1)) : count;
    if (rem && (count1 == '0)) begin
      front1 = '0;
    end else if (rem && rem_front) begin
      front1 = front + IDX_W'(1);
    end else begin
      front1 = front;
    end
  end

  // Insertion step and the new state.
  always_comb begin
    front_next = front1;
    count_next = count1;
    dirty_next = dirty;
    wr_addr    = front1 + count1[IDX_W-1:0];
    case (op_kind)
      KIND_PUSH_BACK: begin
        count_next = count1 + CNT_W'(1);
        dirty_next = 1'b1;
      end
      KIND_PUSH_FRONT: begin
        front_next = front1 - IDX_W'(1);
        wr_addr    = front1 - IDX_W'(1);
        count_next = count1 + CNT_W'(1);
        dirty_next = 1'b1;
      end
      KIND_TAKE_FRONT, KIND_TAKE_BACK: begin
        if (rem) dirty_next = 1'b1;
      end
      KIND_SYNC_ACK: begin
        dirty_next = 1'b0;
      end
      default: begin
        dirty_next = dirty;
      end
    endcase
  end

  // Memory write for insertions.
  always_ff @(posedge clk) begin
    if (ctl.exec && is_push) begin
      mem[wr_addr] <= op_data;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      dirty    <= 1'b0;
      capacity <= CAP_RESET;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (ctl.exec) begin
        front <= front_next;
        count <= count_next;
        dirty <= dirty_next;
      end
    end
  end

  // Result register, shown during the cycle after execution.
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      result.out_valid <= rem;
      result.out_data  <= rem ? rd_data : '0;
      result.evicted   <= rem && is_push;
      result.occupancy <= OCC_W'(count_next);
      result.dirty     <= dirty_next;
    end
  end

endmodule

/* rtl/bounded_deque_with_drop.sv */
// Top level of the bounded deque with drop: controller plus datapath.
//
//   channel   ports                   handshake
//   ------    ---------------------   ------------------------------------------
//   item in   cmd (kind, entry_data)  taken at a clock edge with start high, busy low
//   result    result                  held for one cycle while done is high
//   config    cfg_we, cfg_data        capacity written at an edge with cfg_we high
//
// Each item is handled in order: the ring memory is read at the end it
// touches (registered read port) when the item is taken, then the execute
// state updates pointers and writes. The result appears the cycle after
// that, while busy is already low, so a new item may be started while it is
// shown. Reset clears pointers, count and dirty flag and sets capacity to
// the ring size; the memory is not cleared. The receiver cannot stall results.
module bounded_deque_with_drop (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  bdq_pkg::cmd_t              cmd,
  output logic                       busy,
  output logic                       done,
  output bdq_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]  cfg_data
);
  import bdq_pkg::*;

  ctl_t ctl;

  // Sequencing of each item.
  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // Storage and update logic.
  bdq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule

/* bench/bounded_deque_with_drop_test.sv */
// Self-checking testbench for the bounded deque with drop, with its own deque predictor.
module bounded_deque_with_drop_test;
  import bdq_pkg::*;

  // Kind codes that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  // Cycles with nothing accepted and no result before the run is declared hung.
  localparam int STALL_LIMIT = 500;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  cmd_t                 cmd = '0;
  logic                 busy;
  logic                 done;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CAP_W-1:0]     cfg_data = '0;

  // Items waiting to be driven and results still owed by the block.
  cmd_t                 pending_cmds[$];
  result_t              expected_results[$];

  // Predicted deque contents, pointers, dirty flag and capacity.
  logic [ENTRY_WIDTH-1:0] ring[DEPTH];
  logic [IDX_W-1:0]     ring_head = '0;
  logic [CNT_W-1:0]     ring_count = '0;
  logic                 ring_dirty = 1'b0;
  logic [CAP_W-1:0]     ring_cap = CAP_RESET;

  logic                 item_taken = 1'b0;
  int                   gap_left = 0;
  bit                   bursty = 1'b1;
  bit                   calm = 1'b0;
  int                   idle_cycles = 0;
  int                   errors = 0;

  bounded_deque_with_drop DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Removes the front entry of the predicted deque; an emptied deque restarts at slot zero.
  function automatic logic [ENTRY_WIDTH-1:0] drop_front();
    logic [ENTRY_WIDTH-1:0] v;
    v = ring[ring_head];
    ring_head = ring_head + 1'b1;
    ring_count = ring_count - 1'b1;
    if (ring_count == 0) ring_head = '0;
    return v;
  endfunction

  // Removes the back entry of the predicted deque.
  function automatic logic [ENTRY_WIDTH-1:0] drop_back();
    logic [ENTRY_WIDTH-1:0] v;
    v = ring[IDX_W'(ring_head + ring_count - 1'b1)];
    ring_count = ring_count - 1'b1;
    if (ring_count == 0) ring_head = '0;
    return v;
  endfunction

  // Applies one item to the predicted deque and works out its result.
  task automatic deque_apply(input cmd_t c, output result_t r);
    logic [CMP_W-1:0] lim;
    r = '0;
    // A capacity of zero acts as one; anything above the ring size saturates.
    if (ring_cap == 0) lim = CMP_W'(1);
    else if (ring_cap > DEPTH) lim = CMP_W'(DEPTH);
    else lim = CMP_W'(ring_cap);
    case (c.kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        // A full deque drops the entry at the opposite end first.
        if (ring_count >= lim && ring_count > 0) begin
          r.out_valid = 1'b1;
          r.evicted = 1'b1;
          r.out_data = (c.kind == KIND_PUSH_BACK) ? drop_front() : drop_back();
        end
        if (c.kind == KIND_PUSH_BACK) begin
          ring[IDX_W'(ring_head + ring_count)] = c.entry_data;
        end else begin
          ring_head = ring_head - 1'b1;
          ring[ring_head] = c.entry_data;
        end
        ring_count = ring_count + 1'b1;
        ring_dirty = 1'b1;
      end
      KIND_TAKE_FRONT, KIND_TAKE_BACK: begin
        if (ring_count > 0) begin
          r.out_valid = 1'b1;
          r.out_data = (c.kind == KIND_TAKE_FRONT) ? drop_front() : drop_back();
          ring_dirty = 1'b1;
        end
      end
      KIND_SYNC_ACK: ring_dirty = 1'b0;
      default: ;
    endcase
    r.occupancy = OCC_W'(ring_count);
    r.dirty = ring_dirty;
  endtask

  task automatic report_mismatch(input string what, input logic [ENTRY_WIDTH-1:0] got,
                                 input logic [ENTRY_WIDTH-1:0] want);
    errors++;
    $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
  endtask

  // Monitor: checks results, tracks capacity writes, predicts accepted items and
  // watches for a hung block.
  always @(posedge clk) begin
    result_t want;
    result_t pred;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", result.out_data, '0);
        end else begin
          want = expected_results.pop_front();
          if (result.out_valid !== want.out_valid)
            report_mismatch("out_valid", ENTRY_WIDTH'(result.out_valid),
                            ENTRY_WIDTH'(want.out_valid));
          if (result.out_data !== want.out_data)
            report_mismatch("out_data", result.out_data, want.out_data);
          if (result.evicted !== want.evicted)
            report_mismatch("evicted", ENTRY_WIDTH'(result.evicted),
                            ENTRY_WIDTH'(want.evicted));
          if (result.occupancy !== want.occupancy)
            report_mismatch("occupancy", ENTRY_WIDTH'(result.occupancy),
                            ENTRY_WIDTH'(want.occupancy));
          if (result.dirty !== want.dirty)
            report_mismatch("dirty", ENTRY_WIDTH'(result.dirty), ENTRY_WIDTH'(want.dirty));
        end
      end
      if (cfg_we) ring_cap = cfg_data;
      if (start && !busy) begin
        deque_apply(cmd, pred);
        expected_results.push_back(pred);
      end
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    item_taken <= start && !busy;
  end

  // Driver: offers the oldest pending item, holds it until taken, and idles in bursts.
  always @(negedge clk) begin
    logic go;
    go = 1'b0;
    if (!rst) begin
      if (start && item_taken) begin
        void'(pending_cmds.pop_front());
        if (bursty && !calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 11);
      end
      if (start && !item_taken) go = 1'b1;
      else if (gap_left > 0) gap_left--;
      else if (pending_cmds.size() > 0) go = 1'b1;
      // Swap now and then between bursty stretches and back-to-back stretches.
      if ($urandom_range(0, 99) == 0) bursty = !bursty;
    end
    start <= go;
    if (go) cmd <= pending_cmds[0];
  end

  task automatic queue_cmd(input logic [KIND_W-1:0] kind, input logic [ENTRY_WIDTH-1:0] data);
    cmd_t c;
    c.kind = kind;
    c.entry_data = data;
    pending_cmds.push_back(c);
  endtask

  // Queues random items with the given percentages of pushes and takes; the rest
  // are mostly sync acknowledges with a little noise from unused kinds.
  task automatic queue_random(input int n, input int push_w, input int take_w);
    cmd_t c;
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 15))
        0: c.entry_data = '0;
        1: c.entry_data = '1;
        default: c.entry_data = ENTRY_WIDTH'($urandom);
      endcase
      if (roll < push_w)
        c.kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      else if (roll < push_w + take_w)
        c.kind = $urandom_range(0, 1) ? KIND_TAKE_FRONT : KIND_TAKE_BACK;
      else if (roll < 96)
        c.kind = KIND_SYNC_ACK;
      else
        c.kind = KIND_SPARE_A + KIND_W'($urandom_range(0, 2));
      pending_cmds.push_back(c);
    end
  endtask

  // Waits until every queued item has been taken and every result has come back.
  task automatic settle();
    do @(posedge clk); while (pending_cmds.size() != 0 || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    settle();
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Empty deque, sync acknowledge, ignored kinds, extreme handles and
    // removal of the last entry, all at the reset capacity.
    queue_cmd(KIND_TAKE_FRONT, 32'h1111_1111);
    queue_cmd(KIND_TAKE_BACK, 32'h2222_2222);
    queue_cmd(KIND_SYNC_ACK, '0);
    queue_cmd(KIND_SPARE_A, 32'hDEAD_BEEF);
    queue_cmd(KIND_SPARE_B, '1);
    queue_cmd(KIND_SPARE_C, '0);
    queue_cmd(KIND_PUSH_BACK, '0);
    queue_cmd(KIND_PUSH_BACK, '1);
    queue_cmd(KIND_PUSH_FRONT, 32'h5A5A_A5A5);
    queue_cmd(KIND_TAKE_FRONT, '0);
    queue_cmd(KIND_TAKE_BACK, '0);
    queue_cmd(KIND_TAKE_BACK, '0);
    queue_cmd(KIND_TAKE_FRONT, '0);
    queue_cmd(KIND_SYNC_ACK, '0);

    // Capacity one: every insert into a non-empty deque drops the entry at the far end.
    write_capacity(7'd1);
    queue_cmd(KIND_PUSH_BACK, 32'h0000_00A1);
    queue_cmd(KIND_PUSH_BACK, 32'h0000_00B2);
    queue_cmd(KIND_PUSH_FRONT, 32'h0000_00C3);
    queue_cmd(KIND_TAKE_BACK, '0);

    // Capacity zero behaves as one.
    write_capacity(7'd0);
    queue_cmd(KIND_PUSH_FRONT, 32'h8000_0001);
    queue_cmd(KIND_PUSH_BACK, 32'h7FFF_FFFE);
    queue_cmd(KIND_TAKE_FRONT, '0);
    queue_cmd(KIND_SYNC_ACK, '0);

    // Random phases: saturated capacity filled up, then lowered below the count,
    // then a spread of settings from zero to the ring size.
    write_capacity(7'd127);
    queue_random(150, 70, 20);
    write_capacity(7'd4);
    queue_random(150, 50, 35);
    write_capacity(7'd64);
    queue_random(150, 45, 45);
    write_capacity(7'd0);
    queue_random(150, 50, 40);
    write_capacity(7'd1);
    queue_random(150, 45, 40);
    write_capacity(7'd64);
    queue_random(150, 80, 10);
    write_capacity(CAP_W'($urandom_range(2, 63)));
    queue_random(150, 50, 40);
    calm = 1'b1;
    write_capacity(7'd64);
    queue_random(150, 15, 75);

    settle();
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
